// ----- rtl/thldf_pkg.sv -----
// Package for the two-hash lossy duplicate filter: widths, table entry type,
// opcodes and the two index folds. No dependencies.
`default_nettype none

package thldf_pkg;

    localparam int ADDR_BITS    = 48;
    localparam int PTR_SHIFT    = 3;
    localparam int TABLE_LOG2   = 12;
    localparam int ADDR_FIELD_W = 48;
    localparam int WORD_BITS    = ADDR_BITS - PTR_SHIFT;
    localparam int TABLE_DEPTH  = 1 << TABLE_LOG2;
    localparam int EPOCH_BITS   = 8;

    localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDR_BITS);

    typedef logic [WORD_BITS-1:0]    word_t;
    typedef logic [TABLE_LOG2-1:0]   idx_t;
    typedef logic [EPOCH_BITS-1:0]   epoch_t;
    typedef logic [ADDR_FIELD_W-1:0] addr_t;

    typedef enum logic [0:0] {
        OP_FILTER = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    // An entry is live only if its epoch matches the current one and its
    // word is nonzero.
    typedef struct packed {
        epoch_t epoch;
        word_t  word;
    } entry_t;

    localparam word_t IDX_MASK_W = word_t'(TABLE_DEPTH - 1);

    function automatic word_t word_of(input addr_t slot);
        logic [63:0] masked;
        masked = 64'(slot) & ADDR_MASK;
        return word_t'(masked >> PTR_SHIFT);
    endfunction

    function automatic addr_t addr_of(input word_t w);
        logic [63:0] wide;
        wide = 64'(w) << PTR_SHIFT;
        return addr_t'(wide);
    endfunction

    function automatic idx_t fold_xor(input word_t w);
        word_t h;
        h = (w ^ (w >> TABLE_LOG2)) & IDX_MASK_W;
        return idx_t'(h);
    endfunction

    // Second xor has no effect; keep it as part of the scheme.
    function automatic idx_t fold_sub(input word_t w);
        word_t h;
        h = (w - (w >> TABLE_LOG2)) & IDX_MASK_W;
        h = h ^ (h >> (2 * TABLE_LOG2));
        return idx_t'(h & IDX_MASK_W);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/thldf_req_if.sv -----
// Request channel of the duplicate filter: opcode and slot address.
// Depends on thldf_pkg.
`default_nettype none

interface thldf_req_if;
    import thldf_pkg::*;

    logic  valid;
    logic  ready;
    logic  opcode;
    addr_t slot_address;

    modport source (output valid, output opcode, output slot_address, input ready);
    modport sink   (input valid, input opcode, input slot_address, output ready);
endinterface

`default_nettype wire

// ----- rtl/thldf_rsp_if.sv -----
// Response channel of the duplicate filter: keep flag and kept address.
// Depends on thldf_pkg.
`default_nettype none

interface thldf_rsp_if;
    import thldf_pkg::*;

    logic  valid;
    logic  ready;
    logic  keep;
    addr_t kept_address;

    modport source (output valid, output keep, output kept_address, input ready);
    modport sink   (input valid, input keep, input kept_address, output ready);
endinterface

`default_nettype wire

// ----- rtl/two_hash_lossy_dedup_filter.sv -----
// Top level of the two-hash lossy duplicate filter: two table memories,
// one read-modify-write stage and an output register.
// Depends on thldf_pkg, thldf_req_if and thldf_rsp_if.
//
//   channel | dir | word fields                  | handshake
//   --------+-----+------------------------------+-------------
//   req     | in  | opcode, slot_address         | valid/ready
//   rsp     | out | keep, kept_address           | valid/ready
//
// Flow: one word per clock while rsp.ready holds high and no clearing pass
//   or epoch-wrapping clear is in progress; the tables are read into registers
//   at the accepting edge, then the compare stage checks, writes back and loads
//   the output register. Each table memory has one read and one write port, so
//   the back-to-back rate rests on forwarding the last write.
// Reset: a clearing pass over all 4096 entries zeroes both tables, req.ready low.
// Clear opcode: advances the table epoch; every 256th clear wraps the epoch
//   and runs the same clearing pass.
// Stalls: rsp.ready low holds the output register and then the compare
//   stage; req.ready follows the compare stage.
`default_nettype none

module two_hash_lossy_dedup_filter (
    input  wire               clk,
    input  wire               rst_n,
    thldf_req_if.sink         req,
    thldf_rsp_if.source       rsp
);
    import thldf_pkg::*;

    localparam idx_t   IDX_LAST   = idx_t'(TABLE_DEPTH - 1);
    localparam epoch_t EPOCH_LAST = {EPOCH_BITS{1'b1}};

    // Table memories, read data registered.
    entry_t first_mem  [TABLE_DEPTH];
    entry_t second_mem [TABLE_DEPTH];
    entry_t rd1_reg, rd2_reg;

    // Compare stage.
    logic   s1_vld_reg, s1_vld_next;
    logic   s1_clear_reg;
    word_t  s1_word_reg;
    idx_t   s1_i1_reg, s1_i2_reg;

    // Last write to each table, for the item read in the same cycle.
    logic   fwd1_vld_reg, fwd1_vld_next;
    logic   fwd2_vld_reg, fwd2_vld_next;
    idx_t   fwd1_idx_reg, fwd2_idx_reg;
    entry_t fwd1_ent_reg, fwd2_ent_reg;

    // Output register.
    logic   out_vld_reg, out_vld_next;
    logic   out_keep_reg;
    addr_t  out_addr_reg;

    // Epoch and clearing pass.
    epoch_t epoch_reg, epoch_next;
    logic   pass_reg, pass_next;
    idx_t   clr_idx_reg, clr_idx_next;

    logic   s1_adv, s1_free, accept, wrap_hold;
    word_t  in_word;
    idx_t   in_i1, in_i2;

    entry_t e1, e2;
    logic   live1, live2, hit1, hit2, keep;

    logic   we1, we2;
    idx_t   wa1, wa2;
    entry_t wd1, wd2;
    logic   s1_we1, s1_we2;
    entry_t s1_wd2;

    // ------------------------------------------------------------------
    // Handshake: hold the input while the compare stage is blocked, a
    // clearing pass runs, or a wrapping clear sits in the compare stage.
    // ------------------------------------------------------------------
    assign s1_adv    = s1_vld_reg && (!out_vld_reg || rsp.ready);
    assign s1_free   = !s1_vld_reg || s1_adv;
    assign wrap_hold = s1_vld_reg && s1_clear_reg && (epoch_reg == EPOCH_LAST);
    assign req.ready = s1_free && !pass_reg && !wrap_hold;
    assign accept    = req.valid && req.ready;

    assign in_word = word_of(req.slot_address);
    assign in_i1   = fold_xor(in_word);
    assign in_i2   = fold_sub(in_word);

    // ------------------------------------------------------------------
    // Compare: take forwarded data where the previous write hit our entry.
    // ------------------------------------------------------------------
    always_comb
    begin
        e1 = (fwd1_vld_reg && fwd1_idx_reg == s1_i1_reg) ? fwd1_ent_reg : rd1_reg;
        e2 = (fwd2_vld_reg && fwd2_idx_reg == s1_i2_reg) ? fwd2_ent_reg : rd2_reg;

        live1 = (e1.epoch == epoch_reg) && (e1.word != '0);
        live2 = (e2.epoch == epoch_reg) && (e2.word != '0);
        hit1  = (e1.epoch == epoch_reg) && (e1.word == s1_word_reg);
        hit2  = (e2.epoch == epoch_reg) && (e2.word == s1_word_reg);

        // Drop a clear, a zero word and a hit in either table.
        keep = !s1_clear_reg && (s1_word_reg != '0) && !hit1 && !hit2;

        // Fill table one if empty, else table two if empty; when both are
        // full, overwrite table one and empty table two.
        s1_we1 = s1_adv && keep && (!live1 || live2);
        s1_we2 = s1_adv && keep && live1;
        s1_wd2 = live2 ? entry_t'{epoch: epoch_reg, word: '0}
                       : entry_t'{epoch: epoch_reg, word: s1_word_reg};
    end

    // Write ports: the clearing pass owns both while it runs.
    always_comb
    begin
        if (pass_reg)
        begin
            we1 = 1'b1;
            we2 = 1'b1;
            wa1 = clr_idx_reg;
            wa2 = clr_idx_reg;
            wd1 = entry_t'{epoch: epoch_reg, word: '0};
            wd2 = entry_t'{epoch: epoch_reg, word: '0};
        end
        else
        begin
            we1 = s1_we1;
            we2 = s1_we2;
            wa1 = s1_i1_reg;
            wa2 = s1_i2_reg;
            wd1 = entry_t'{epoch: epoch_reg, word: s1_word_reg};
            wd2 = s1_wd2;
        end
    end

    // Memories: read on accept, old data on a same-address write.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd1_reg <= first_mem[in_i1];
            rd2_reg <= second_mem[in_i2];
        end
        if (we1)
        begin
            first_mem[wa1] <= wd1;
        end
        if (we2)
        begin
            second_mem[wa2] <= wd2;
        end
    end

    // ------------------------------------------------------------------
    // Control next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_vld_next   = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_reg);
        out_vld_next  = s1_adv ? 1'b1 : (rsp.ready ? 1'b0 : out_vld_reg);
        fwd1_vld_next = pass_reg ? 1'b0 : (s1_we1 ? 1'b1 : fwd1_vld_reg);
        fwd2_vld_next = pass_reg ? 1'b0 : (s1_we2 ? 1'b1 : fwd2_vld_reg);

        epoch_next   = epoch_reg;
        pass_next    = pass_reg;
        clr_idx_next = clr_idx_reg;

        if (pass_reg)
        begin
            clr_idx_next = clr_idx_reg + idx_t'(1);
            if (clr_idx_reg == IDX_LAST)
            begin
                pass_next = 1'b0;
            end
        end
        else if (s1_adv && s1_clear_reg)
        begin
            // Advance the epoch; on wrap, sweep out stale tags.
            epoch_next = epoch_reg + epoch_t'(1);
            if (epoch_reg == EPOCH_LAST)
            begin
                pass_next    = 1'b1;
                clr_idx_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            fwd1_vld_reg <= 1'b0;
            fwd2_vld_reg <= 1'b0;
            epoch_reg    <= '0;
            pass_reg     <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            s1_vld_reg   <= s1_vld_next;
            out_vld_reg  <= out_vld_next;
            fwd1_vld_reg <= fwd1_vld_next;
            fwd2_vld_reg <= fwd2_vld_next;
            epoch_reg    <= epoch_next;
            pass_reg     <= pass_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_clear_reg <= (op_t'(req.opcode) == OP_CLEAR);
            s1_word_reg  <= in_word;
            s1_i1_reg    <= in_i1;
            s1_i2_reg    <= in_i2;
        end
        if (s1_we1)
        begin
            fwd1_idx_reg <= wa1;
            fwd1_ent_reg <= wd1;
        end
        if (s1_we2)
        begin
            fwd2_idx_reg <= wa2;
            fwd2_ent_reg <= wd2;
        end
        if (s1_adv)
        begin
            out_keep_reg <= keep;
            out_addr_reg <= keep ? addr_of(s1_word_reg) : '0;
        end
    end

    assign rsp.valid        = out_vld_reg;
    assign rsp.keep         = out_keep_reg;
    assign rsp.kept_address = out_addr_reg;

endmodule

`default_nettype wire

// ----- verif/two_hash_lossy_dedup_filter_tb.sv -----
// Self-checking testbench for two_hash_lossy_dedup_filter: random and directed
// slot-address streams, a two-table shadow predictor and a result checker.
// Depends on thldf_pkg, thldf_req_if, thldf_rsp_if and the filter RTL.
`default_nettype none

module two_hash_lossy_dedup_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import thldf_pkg::*;

    // Cycles with no word moving on either channel before the run is called
    // hung. The worst honest gap is a full table wipe (after reset or
    // on an epoch wrap) plus the long receiver hold-off, so allow plenty.
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int POOL_SIZE = 32;

    // One expected result word.
    typedef struct packed {
        logic  keep;
        addr_t addr;
    } verdict_t;

    // Shadow of both hash tables; turns each accepted request word into the
    // verdict the filter must return and checks returned words in order.
    class dedup_tracker;
        word_t    first_tbl[TABLE_DEPTH];
        word_t    second_tbl[TABLE_DEPTH];
        verdict_t pending_verdicts[$];
        int       mismatches;
        int       kept;
        int       dropped;
        int       clears;

        function new();
            wipe();
            mismatches = 0;
            kept = 0;
            dropped = 0;
            clears = 0;
        endfunction

        function void wipe();
            foreach (first_tbl[i])
            begin
                first_tbl[i] = '0;
                second_tbl[i] = '0;
            end
        endfunction

        function void note_request(op_t op, addr_t slot);
            logic [63:0] masked;
            word_t       w;
            word_t       xor_fold;
            word_t       sub_fold;
            idx_t        ia;
            idx_t        ib;
            verdict_t    v;
            v.keep = 1'b0;
            v.addr = '0;
            if (op == OP_CLEAR)
            begin
                wipe();
                clears++;
            end
            else
            begin
                masked = 64'(slot) & ADDR_MASK;
                w = word_t'(masked >> PTR_SHIFT);
                xor_fold = w ^ (w >> TABLE_LOG2);
                // The scheme also xors the masked sum with itself shifted by
                // twice the index width; that term is always zero.
                sub_fold = w - (w >> TABLE_LOG2);
                ia = idx_t'(xor_fold);
                ib = idx_t'(sub_fold);
                if (w != '0 && first_tbl[ia] != w && second_tbl[ib] != w)
                begin
                    if (first_tbl[ia] == '0)
                        first_tbl[ia] = w;
                    else if (second_tbl[ib] == '0)
                        second_tbl[ib] = w;
                    else
                    begin
                        first_tbl[ia] = w;
                        second_tbl[ib] = '0;
                    end
                    v.keep = 1'b1;
                    v.addr = addr_t'(64'(w) << PTR_SHIFT);
                end
            end
            if (op != OP_CLEAR)
            begin
                if (v.keep)
                    kept++;
                else
                    dropped++;
            end
            pending_verdicts.push_back(v);
        endfunction

        function void check_result(logic keep, addr_t addr);
            verdict_t want;
            if (pending_verdicts.size() == 0)
            begin
                $error("unexpected result word: keep=%0b kept_address=%h", keep, addr);
                mismatches++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (keep !== want.keep)
            begin
                $error("keep: expected %0b, actual %0b", want.keep, keep);
                mismatches++;
            end
            if (addr !== want.addr)
            begin
                $error("kept_address: expected %h, actual %h", want.addr, addr);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    thldf_req_if req_ch();
    thldf_rsp_if rsp_ch();

    two_hash_lossy_dedup_filter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    dedup_tracker tracker = new();

    // Idle controls shared between the driving processes.
    bit tx_gaps_on;
    bit rsp_stalls_on;
    bit hold_off_request;
    int words_sent;

    // Addresses built to collide: every word in a group shares its first-table
    // index, and words that share a twist also share the second-table index,
    // so repeats, second-table fills and evictions all happen often.
    word_t pool[POOL_SIZE];

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Build the collision pool: 2 base pairs x 4 twists x 4 high parts.
    task automatic build_pool();
        logic [11:0]            lo;
        logic [11:0]            mid;
        logic [11:0]            twist;
        logic [WORD_BITS-25:0]  hi;
        int                     n;
        n = 0;
        for (int g = 0; g < 2; g++)
        begin
            lo = 12'($urandom);
            mid = 12'($urandom);
            for (int t = 0; t < 4; t++)
            begin
                twist = (t == 0) ? 12'h000 : 12'($urandom);
                for (int h = 0; h < 4; h++)
                begin
                    hi = (WORD_BITS - 24)'($urandom_range(1, 32'h7fff_ffff));
                    pool[n] = word_t'({hi, mid ^ twist, lo ^ twist});
                    n++;
                end
            end
        end
    endtask

    // Slot address of a word with random pointer bits below it.
    function automatic addr_t slot_of(word_t w);
        return addr_t'(64'(w) << PTR_SHIFT) | addr_t'($urandom_range(0, (1 << PTR_SHIFT) - 1));
    endfunction

    // Offer one request word and hold it until the filter takes it, then
    // maybe drop valid for a random gap.
    task automatic send_word(op_t op, addr_t slot);
        req_ch.valid <= 1'b1;
        req_ch.opcode <= op;
        req_ch.slot_address <= slot;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        tracker.note_request(op, slot);
        words_sent++;
        if (tx_gaps_on && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Drop valid and hold until every expected result word is back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (tracker.pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Random traffic: mostly colliding pool words, some noise, rare clears.
    task automatic send_random(int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                send_word(OP_CLEAR, addr_t'({$urandom, $urandom}));
            else if (pick < 7)
                send_word(OP_FILTER, addr_t'($urandom_range(0, (1 << PTR_SHIFT) - 1)));
            else if (pick < 15)
                send_word(OP_FILTER, addr_t'({$urandom, $urandom}));
            else
                send_word(OP_FILTER, slot_of(pool[$urandom_range(0, POOL_SIZE - 1)]));
        end
    endtask

    // Response side: check every accepted word, stall in random bursts and
    // run the long hold-off when asked, counting its cycles here.
    initial
    begin : rsp_side
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                tracker.check_result(rsp_ch.keep, rsp_ch.kept_address);
            if (hold_off_request)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (rsp_stalls_on && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 17) - 1;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        word_t a_word;
        word_t b_word;
        word_t c_word;
        tx_gaps_on = 1'b1;
        rsp_stalls_on = 1'b1;
        hold_off_request = 1'b0;
        words_sent = 0;
        rst_n = 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.opcode <= OP_FILTER;
        req_ch.slot_address <= '0;
        build_pool();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero word (whole and with pointer bits), smallest nonzero
        // word and its repeat, all ones, clear, then a three-way collision
        // that walks first-table fill, second-table fill and eviction.
        a_word = pool[0];
        b_word = pool[1];
        c_word = pool[2];
        send_word(OP_FILTER, '0);
        send_word(OP_FILTER, addr_t'((1 << PTR_SHIFT) - 1));
        send_word(OP_FILTER, addr_t'(1 << PTR_SHIFT));
        send_word(OP_FILTER, addr_t'((2 << PTR_SHIFT) - 1));
        send_word(OP_FILTER, '1);
        send_word(OP_FILTER, '1);
        send_word(OP_CLEAR, '1);
        send_word(OP_FILTER, addr_t'(1 << PTR_SHIFT));
        send_word(OP_FILTER, '1);
        send_word(OP_FILTER, slot_of(a_word));
        send_word(OP_FILTER, slot_of(b_word));
        send_word(OP_FILTER, slot_of(b_word));
        send_word(OP_FILTER, slot_of(c_word));
        send_word(OP_FILTER, slot_of(a_word));
        send_word(OP_FILTER, slot_of(c_word));
        send_word(OP_FILTER, slot_of(a_word));
        send_word(OP_FILTER, slot_of(b_word));
        send_word(OP_CLEAR, '0);
        send_word(OP_FILTER, addr_t'({24{2'b10}}));
        send_word(OP_FILTER, addr_t'({24{2'b01}}));
        send_word(OP_FILTER, addr_t'({24{2'b10}}));

        // Pause the sender until the pipeline is empty.
        drain();

        send_random(400);

        // Long receiver hold-off while the sender keeps pushing, so the
        // output and compare stages fill and req.ready drops.
        tx_gaps_on = 1'b0;
        hold_off_request = 1'b1;
        send_random(100);
        tx_gaps_on = 1'b1;

        // Run the table epoch through a full wrap: enough clears to force the
        // wipe pass, with pool words in between so stale entries of every
        // epoch exist and must not come back to life.
        for (int i = 0; i < 260; i++)
        begin
            send_word(OP_CLEAR, addr_t'({$urandom, $urandom}));
            if ($urandom_range(0, 1) == 0)
                send_word(OP_FILTER, slot_of(pool[$urandom_range(0, POOL_SIZE - 1)]));
        end
        send_random(400);

        // Final stretch at full rate on both sides.
        tx_gaps_on = 1'b0;
        rsp_stalls_on = 1'b0;
        send_random(250);

        drain();
        repeat (20) @(posedge clk);

        if (tracker.pending_verdicts.size() != 0)
        begin
            $error("%0d result words never arrived", tracker.pending_verdicts.size());
            tracker.mismatches++;
        end
        $display("covered %0d request words: %0d passed on, %0d dropped, %0d clears",
                 words_sent, tracker.kept, tracker.dropped, tracker.clears);
        $display("including an epoch wrap, a full-pipeline hold-off and collision evictions");
        if (tracker.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
